// ===== src/crcdf_pkg.sv =====
// Package for the CRC-16 frame deframer: parser states, result record,
// constants and the byte-wide CRC-16/CCITT-FALSE update. No dependencies.
package crcdf_pkg;

    localparam logic [7:0]  MAGIC_FIRST   = 8'hA5;
    localparam logic [7:0]  MAGIC_SECOND  = 8'h5A;
    localparam logic [15:0] CRC_SEED      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] LIMIT_RESET   = 16'd1024;

    typedef enum logic [3:0] {
        ST_MAGIC1  = 4'd0,
        ST_MAGIC2  = 4'd1,
        ST_NONCE_L = 4'd2,
        ST_NONCE_H = 4'd3,
        ST_LEN_L   = 4'd4,
        ST_LEN_H   = 4'd5,
        ST_TYPE    = 4'd6,
        ST_SEQ     = 4'd7,
        ST_PAYLOAD = 4'd8,
        ST_CRC_L   = 4'd9,
        ST_CRC_H   = 4'd10
    } parse_state_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_REPORT  = 1'b1
    } out_kind_t;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  out_byte;
        logic [15:0] frame_nonce;
        logic [7:0]  frame_type;
        logic [7:0]  frame_sequence;
        logic [15:0] frame_length;
        logic        crc_ok;
        logic        last;
    } result_t;

    // One byte of CRC-16/CCITT-FALSE, MSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== src/crcdf_if.sv =====
// Valid/ready channel interfaces for the deframer's byte input and result output.
// Depends on nothing; the top level and its users connect through these.
interface crcdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       resync;

    modport source (output valid, output rx_byte, output resync, input ready);
    modport sink   (input valid, input rx_byte, input resync, output ready);
endinterface

interface crcdf_out_if;
    logic        valid;
    logic        ready;
    logic        out_kind;
    logic [7:0]  out_byte;
    logic [15:0] frame_nonce;
    logic [7:0]  frame_type;
    logic [7:0]  frame_sequence;
    logic [15:0] frame_length;
    logic        crc_ok;
    logic        last;

    modport source (output valid, output out_kind, output out_byte, output frame_nonce,
                    output frame_type, output frame_sequence, output frame_length,
                    output crc_ok, output last, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input frame_nonce,
                    input frame_type, input frame_sequence, input frame_length,
                    input crc_ok, input last, output ready);
endinterface

// ===== src/crc16_frame_deframer_core.sv =====
// Top level of the CRC-16 frame deframer: input stage, parser, result register.
// Depends on crcdf_pkg, crcdf_in_if, crcdf_out_if and crcdf_parser.
//
// The deframer takes one received byte per item on the rx channel and hunts
// for the magic pair 0xA5 0x5A, then reads a little-endian nonce and length,
// a type byte, a sequence byte, the payload and a little-endian CRC. Each
// payload byte leaves on the res channel as a payload item carrying the
// current header fields; after the second CRC byte one report item (last
// high) tells whether the CRC-16/CCITT-FALSE over nonce through payload
// matched. A frame whose length exceeds payload_limit is dropped silently.
// Setting resync on an item sends the decoder back to hunting before that
// byte is looked at. The block accepts one item every clock cycle while its
// result register is free or being emptied; an item passes through an input
// register, the parser logic (state step and byte-wide CRC update) and, if it
// yields a result, a result register that presents it on res. A result waiting
// in the output register does not stop the input register from filling, and
// the whole path stalls only while both hold an item. Write payload_limit
// through cfg_wr_en/cfg_wr_data only while the block is idle; it resets to 1024.
module crc16_frame_deframer_core (
    input  logic          clk,
    input  logic          rst_n,
    crcdf_in_if.sink      rx,
    crcdf_out_if.source   res,
    input  logic          cfg_wr_en,
    input  logic [15:0]   cfg_wr_data
);

    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        in_resync_reg;
    logic        out_vld_reg;
    crcdf_pkg::result_t out_reg;
    logic [15:0] limit_reg;

    logic               advance;
    logic               step_valid;
    crcdf_pkg::result_t step_res;

    // The parser moves when the input stage holds an item and the result
    // register is free or being emptied this cycle.
    assign advance  = in_vld_reg && (!out_vld_reg || res.ready);
    assign rx.ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= crcdf_pkg::LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_vld_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg   <= rx.rx_byte;
            in_resync_reg <= rx.resync;
        end
    end

    crcdf_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .rx_byte       (in_byte_reg),
        .resync        (in_resync_reg),
        .payload_limit (limit_reg),
        .res_valid     (step_valid),
        .res           (step_res)
    );

    // Result register: loaded when a step produces a result, otherwise
    // emptied once the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= step_valid;
        end
        else if (res.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_valid)
        begin
            out_reg <= step_res;
        end
    end

    assign res.valid          = out_vld_reg;
    assign res.out_kind       = out_reg.out_kind;
    assign res.out_byte       = out_reg.out_byte;
    assign res.frame_nonce    = out_reg.frame_nonce;
    assign res.frame_type     = out_reg.frame_type;
    assign res.frame_sequence = out_reg.frame_sequence;
    assign res.frame_length   = out_reg.frame_length;
    assign res.crc_ok         = out_reg.crc_ok;
    assign res.last           = out_reg.last;

endmodule

// ===== src/crcdf_parser.sv =====
// Frame parser state machine with header registers and running CRC.
// Depends on crcdf_pkg; advances by one byte whenever step is high.
module crcdf_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    input  logic                resync,
    input  logic [15:0]         payload_limit,
    output logic                res_valid,
    output crcdf_pkg::result_t  res
);

    crcdf_pkg::parse_state_t state_reg, state_next, cur_state;
    logic [15:0] nonce_reg, nonce_next;
    logic [15:0] length_reg, length_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  sequence_reg, sequence_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_low_reg, crc_low_next;

    logic [15:0] cur_count;
    logic [15:0] count_inc;
    logic [15:0] crc_upd;
    logic [15:0] full_length;

    // A resync request puts the decoder back into hunting before this byte.
    assign cur_state   = resync ? crcdf_pkg::ST_MAGIC1 : state_reg;
    assign cur_count   = resync ? 16'd0 : count_reg;
    assign count_inc   = cur_count + 16'd1;
    assign crc_upd     = crcdf_pkg::crc16_byte(crc_reg, rx_byte);
    assign full_length = {rx_byte, length_reg[7:0]};

    // Next state.
    always_comb
    begin
        case (cur_state)
            crcdf_pkg::ST_MAGIC1:
            begin
                state_next = (rx_byte == crcdf_pkg::MAGIC_FIRST) ?
                             crcdf_pkg::ST_MAGIC2 : crcdf_pkg::ST_MAGIC1;
            end
            crcdf_pkg::ST_MAGIC2:
            begin
                if (rx_byte == crcdf_pkg::MAGIC_SECOND)
                begin
                    state_next = crcdf_pkg::ST_NONCE_L;
                end
                else if (rx_byte == crcdf_pkg::MAGIC_FIRST)
                begin
                    state_next = crcdf_pkg::ST_MAGIC2;
                end
                else
                begin
                    state_next = crcdf_pkg::ST_MAGIC1;
                end
            end
            crcdf_pkg::ST_NONCE_L: state_next = crcdf_pkg::ST_NONCE_H;
            crcdf_pkg::ST_NONCE_H: state_next = crcdf_pkg::ST_LEN_L;
            crcdf_pkg::ST_LEN_L:   state_next = crcdf_pkg::ST_LEN_H;
            crcdf_pkg::ST_LEN_H:
            begin
                if (full_length > payload_limit)
                begin
                    // An oversized frame is dropped; its high length byte may
                    // itself be the start of the next magic pair.
                    state_next = (rx_byte == crcdf_pkg::MAGIC_FIRST) ?
                                 crcdf_pkg::ST_MAGIC2 : crcdf_pkg::ST_MAGIC1;
                end
                else
                begin
                    state_next = crcdf_pkg::ST_TYPE;
                end
            end
            crcdf_pkg::ST_TYPE: state_next = crcdf_pkg::ST_SEQ;
            crcdf_pkg::ST_SEQ:
            begin
                state_next = (length_reg == 16'd0) ?
                             crcdf_pkg::ST_CRC_L : crcdf_pkg::ST_PAYLOAD;
            end
            crcdf_pkg::ST_PAYLOAD:
            begin
                state_next = (count_inc == length_reg) ?
                             crcdf_pkg::ST_CRC_L : crcdf_pkg::ST_PAYLOAD;
            end
            crcdf_pkg::ST_CRC_L: state_next = crcdf_pkg::ST_CRC_H;
            crcdf_pkg::ST_CRC_H: state_next = crcdf_pkg::ST_MAGIC1;
            default:             state_next = crcdf_pkg::ST_MAGIC1;
        endcase
    end

    // Datapath registers and the result.
    always_comb
    begin
        nonce_next    = nonce_reg;
        length_next   = length_reg;
        type_next     = type_reg;
        sequence_next = sequence_reg;
        count_next    = cur_count;
        crc_next      = crc_reg;
        crc_low_next  = crc_low_reg;
        res_valid     = 1'b0;
        res.out_kind       = crcdf_pkg::KIND_PAYLOAD;
        res.out_byte       = 8'd0;
        res.frame_nonce    = nonce_reg;
        res.frame_type     = type_reg;
        res.frame_sequence = sequence_reg;
        res.frame_length   = length_reg;
        res.crc_ok         = 1'b0;
        res.last           = 1'b0;
        case (cur_state)
            crcdf_pkg::ST_MAGIC2:
            begin
                if (rx_byte == crcdf_pkg::MAGIC_SECOND)
                begin
                    crc_next = crcdf_pkg::CRC_SEED;
                end
            end
            crcdf_pkg::ST_NONCE_L:
            begin
                nonce_next = {8'd0, rx_byte};
                crc_next   = crc_upd;
            end
            crcdf_pkg::ST_NONCE_H:
            begin
                nonce_next = {rx_byte, nonce_reg[7:0]};
                crc_next   = crc_upd;
            end
            crcdf_pkg::ST_LEN_L:
            begin
                length_next = {8'd0, rx_byte};
                crc_next    = crc_upd;
            end
            crcdf_pkg::ST_LEN_H:
            begin
                length_next = full_length;
                crc_next    = crc_upd;
            end
            crcdf_pkg::ST_TYPE:
            begin
                type_next = rx_byte;
                crc_next  = crc_upd;
            end
            crcdf_pkg::ST_SEQ:
            begin
                sequence_next = rx_byte;
                crc_next      = crc_upd;
                count_next    = 16'd0;
            end
            crcdf_pkg::ST_PAYLOAD:
            begin
                crc_next     = crc_upd;
                count_next   = count_inc;
                res_valid    = 1'b1;
                res.out_byte = rx_byte;
            end
            crcdf_pkg::ST_CRC_L:
            begin
                crc_low_next = rx_byte;
            end
            crcdf_pkg::ST_CRC_H:
            begin
                count_next   = 16'd0;
                res_valid    = 1'b1;
                res.out_kind = crcdf_pkg::KIND_REPORT;
                res.crc_ok   = (crc_reg == {rx_byte, crc_low_reg});
                res.last     = 1'b1;
            end
            default:
            begin
                count_next = cur_count;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= crcdf_pkg::ST_MAGIC1;
            nonce_reg    <= 16'd0;
            length_reg   <= 16'd0;
            type_reg     <= 8'd0;
            sequence_reg <= 8'd0;
            count_reg    <= 16'd0;
            crc_reg      <= crcdf_pkg::CRC_SEED;
            crc_low_reg  <= 8'd0;
        end
        else if (step)
        begin
            state_reg    <= state_next;
            nonce_reg    <= nonce_next;
            length_reg   <= length_next;
            type_reg     <= type_next;
            sequence_reg <= sequence_next;
            count_reg    <= count_next;
            crc_reg      <= crc_next;
            crc_low_reg  <= crc_low_next;
        end
    end

endmodule

// ===== tb/sv/tb_crc16_frame_deframer_core.sv =====
// Self-checking testbench for crc16_frame_deframer_core: random and directed byte streams
// are checked against a cycle-free decoder model kept inside the bench.
// Depends on crcdf_pkg, crcdf_in_if, crcdf_out_if and the deframer RTL.
module tb_crc16_frame_deframer_core;
    timeunit 1ns;
    timeprecision 1ps;

    // No accepted item on either channel for this many cycles means the block hung.
    localparam int WATCHDOG_LIMIT  = 2000;
    // The block holds an item in its input register and one in its result register,
    // so the settle wait after the last result leaves it certainly empty.
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 8;
    // Length of the long receiver hold-off used to fill the block up.
    localparam int HOLD_OFF_CYCLES = 150;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    crcdf_in_if  rx_ch();
    crcdf_out_if res_ch();

    crc16_frame_deframer_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx_ch),
        .res         (res_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Idling percentages for the sender and the receiver, and a one-shot request
    // for a long receiver hold-off.
    int src_idle_pct;
    int sink_idle_pct;
    int hold_request;

    int idle_cycles;
    int mismatch_count;
    // Bytes sent as part of frames; noise bytes do not count toward a phase's budget.
    int frame_items;

    // Results that the decoder model has produced and the block still owes.
    crcdf_pkg::result_t decoded_queue[$];
    logic [7:0]         frame_payload[$];
    logic [7:0]         wire_bytes[$];

    // Decoder model state, mirroring the block's parser and its limit register.
    crcdf_pkg::parse_state_t hunt_state;
    logic [15:0]  limit_shadow;
    logic [15:0]  hdr_nonce;
    logic [15:0]  hdr_length;
    logic [7:0]   hdr_type;
    logic [7:0]   hdr_seq;
    logic [15:0]  payload_seen;
    logic [15:0]  crc_acc;
    logic [7:0]   crc_low_rx;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // CRC-16/CCITT-FALSE, one message bit at a time, MSB first.
    function automatic logic [15:0] crc16_step(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] acc;
        logic        feedback;
        acc = crc_in;
        for (int k = 7; k >= 0; k--)
        begin
            feedback = acc[15] ^ data[k];
            acc = {acc[14:0], 1'b0};
            if (feedback)
            begin
                acc = acc ^ crcdf_pkg::CRC_POLY;
            end
        end
        return acc;
    endfunction

    // Both result kinds carry the header of the frame in progress.
    function automatic crcdf_pkg::result_t make_result(input crcdf_pkg::out_kind_t kind,
                                                       input logic [7:0] data,
                                                       input logic ok);
        crcdf_pkg::result_t r;
        r.out_kind       = kind;
        r.out_byte       = data;
        r.frame_nonce    = hdr_nonce;
        r.frame_type     = hdr_type;
        r.frame_sequence = hdr_seq;
        r.frame_length   = hdr_length;
        r.crc_ok         = ok;
        r.last           = kind;
        return r;
    endfunction

    // Steps the decoder model by one accepted item and queues any result it causes.
    task automatic decode_byte(input logic [7:0] data, input logic rs);
        // A resync drops whatever was in progress before this byte is looked at.
        if (rs)
        begin
            hunt_state   = crcdf_pkg::ST_MAGIC1;
            payload_seen = '0;
        end
        case (hunt_state)
            crcdf_pkg::ST_MAGIC1:
            begin
                if (data == crcdf_pkg::MAGIC_FIRST)
                begin
                    hunt_state = crcdf_pkg::ST_MAGIC2;
                end
            end
            crcdf_pkg::ST_MAGIC2:
            begin
                // Further first-magic bytes keep the decoder waiting here.
                if (data == crcdf_pkg::MAGIC_SECOND)
                begin
                    hunt_state = crcdf_pkg::ST_NONCE_L;
                    crc_acc    = crcdf_pkg::CRC_SEED;
                end
                else if (data != crcdf_pkg::MAGIC_FIRST)
                begin
                    hunt_state = crcdf_pkg::ST_MAGIC1;
                end
            end
            crcdf_pkg::ST_NONCE_L:
            begin
                hdr_nonce  = {8'h00, data};
                crc_acc    = crc16_step(crc_acc, data);
                hunt_state = crcdf_pkg::ST_NONCE_H;
            end
            crcdf_pkg::ST_NONCE_H:
            begin
                hdr_nonce  = {data, hdr_nonce[7:0]};
                crc_acc    = crc16_step(crc_acc, data);
                hunt_state = crcdf_pkg::ST_LEN_L;
            end
            crcdf_pkg::ST_LEN_L:
            begin
                hdr_length = {8'h00, data};
                crc_acc    = crc16_step(crc_acc, data);
                hunt_state = crcdf_pkg::ST_LEN_H;
            end
            crcdf_pkg::ST_LEN_H:
            begin
                hdr_length = {data, hdr_length[7:0]};
                crc_acc    = crc16_step(crc_acc, data);
                // An oversized frame is dropped; a high length byte equal to the
                // first magic counts as the start of a new frame.
                if (hdr_length > limit_shadow)
                begin
                    if (data == crcdf_pkg::MAGIC_FIRST)
                    begin
                        hunt_state = crcdf_pkg::ST_MAGIC2;
                    end
                    else
                    begin
                        hunt_state = crcdf_pkg::ST_MAGIC1;
                    end
                end
                else
                begin
                    hunt_state = crcdf_pkg::ST_TYPE;
                end
            end
            crcdf_pkg::ST_TYPE:
            begin
                hdr_type   = data;
                crc_acc    = crc16_step(crc_acc, data);
                hunt_state = crcdf_pkg::ST_SEQ;
            end
            crcdf_pkg::ST_SEQ:
            begin
                hdr_seq      = data;
                crc_acc      = crc16_step(crc_acc, data);
                payload_seen = '0;
                if (hdr_length == 16'd0)
                begin
                    hunt_state = crcdf_pkg::ST_CRC_L;
                end
                else
                begin
                    hunt_state = crcdf_pkg::ST_PAYLOAD;
                end
            end
            crcdf_pkg::ST_PAYLOAD:
            begin
                crc_acc      = crc16_step(crc_acc, data);
                payload_seen = payload_seen + 16'd1;
                if (payload_seen == hdr_length)
                begin
                    hunt_state = crcdf_pkg::ST_CRC_L;
                end
                decoded_queue.insert(decoded_queue.size(),
                                     make_result(crcdf_pkg::KIND_PAYLOAD, data, 1'b0));
            end
            crcdf_pkg::ST_CRC_L:
            begin
                crc_low_rx = data;
                hunt_state = crcdf_pkg::ST_CRC_H;
            end
            crcdf_pkg::ST_CRC_H:
            begin
                decoded_queue.insert(decoded_queue.size(),
                                     make_result(crcdf_pkg::KIND_REPORT, 8'h00,
                                                 crc_acc == {data, crc_low_rx}));
                hunt_state   = crcdf_pkg::ST_MAGIC1;
                payload_seen = '0;
            end
            default:
            begin
                hunt_state = crcdf_pkg::ST_MAGIC1;
            end
        endcase
    endtask

    // Offers one item, with random idle cycles in front of it, and waits until the
    // block takes it. Valid stays high on return so back-to-back items need no gap.
    task automatic send_byte(input logic [7:0] data, input logic rs);
        while ($urandom_range(99) < src_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= data;
        rx_ch.resync  <= rs;
        @(posedge clk);
        while (rx_ch.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        decode_byte(data, rs);
    endtask

    // Builds a frame around frame_payload and sends the bytes from index first up to
    // (not including) stop; a negative stop sends the whole frame.
    task automatic send_frame(input logic [15:0] nonce, input logic [15:0] frame_len,
                              input logic [7:0] ftype, input logic [7:0] fseq,
                              input bit bad_crc, input bit lead_resync,
                              input int first, input int stop);
        logic [63:0] header;
        logic [15:0] crc;
        int          end_idx;
        header = {fseq, ftype, frame_len[15:8], frame_len[7:0],
                  nonce[15:8], nonce[7:0], crcdf_pkg::MAGIC_SECOND, crcdf_pkg::MAGIC_FIRST};
        wire_bytes.delete();
        for (int i = 0; i < 8; i++)
        begin
            wire_bytes.insert(wire_bytes.size(), header[8*i +: 8]);
        end
        foreach (frame_payload[i])
        begin
            wire_bytes.insert(wire_bytes.size(), frame_payload[i]);
        end
        // The CRC covers everything after the two magic bytes.
        crc = crcdf_pkg::CRC_SEED;
        for (int i = 2; i < wire_bytes.size(); i++)
        begin
            crc = crc16_step(crc, wire_bytes[i]);
        end
        if (bad_crc)
        begin
            crc = crc ^ 16'($urandom_range(1, 65535));
        end
        wire_bytes.insert(wire_bytes.size(), crc[7:0]);
        wire_bytes.insert(wire_bytes.size(), crc[15:8]);
        end_idx = (stop < 0 || stop > wire_bytes.size()) ? wire_bytes.size() : stop;
        for (int i = first; i < end_idx; i++)
        begin
            send_byte(wire_bytes[i], lead_resync && (i == first));
            frame_items++;
        end
    endtask

    task automatic fill_payload(input int count);
        frame_payload.delete();
        repeat (count)
        begin
            frame_payload.insert(frame_payload.size(), 8'($urandom));
        end
    endtask

    // Picks a length against the current limit: mostly short legal payloads, a few
    // long ones, and some oversized headers that the block has to drop.
    task automatic send_random_frame(input bit lead_resync, input int stop);
        int lim;
        int roll;
        int frame_len;
        int hi;
        lim  = int'(limit_shadow);
        roll = $urandom_range(99);
        if (roll < 10 && lim < 65535)
        begin
            if (lim < 'hA500 && $urandom_range(1) == 1)
            begin
                frame_len = int'({8'hA5, 8'($urandom)});
            end
            else
            begin
                hi        = (lim + 300 > 65535) ? 65535 : lim + 300;
                frame_len = $urandom_range(hi, lim + 1);
            end
            frame_payload.delete();
            // Only the header matters: the decoder stops looking after the length.
            send_frame(16'($urandom), 16'(frame_len), 8'($urandom), 8'($urandom),
                       1'b0, lead_resync, 0, (stop > 0 && stop < 6) ? stop : 6);
        end
        else
        begin
            if (roll < 14 && lim > 40)
            begin
                frame_len = $urandom_range(lim > 300 ? 300 : lim, 41);
            end
            else
            begin
                frame_len = $urandom_range(lim < 12 ? lim : 12, 0);
            end
            fill_payload(frame_len);
            send_frame(16'($urandom), 16'(frame_len), 8'($urandom), 8'($urandom),
                       $urandom_range(5) == 0, lead_resync, 0, stop);
        end
    endtask

    // Short bursts of line noise, heavy on the first magic byte.
    task automatic send_noise();
        int count;
        count = $urandom_range(6, 1);
        repeat (count)
        begin
            send_byte(($urandom_range(2) == 0) ? crcdf_pkg::MAGIC_FIRST : 8'($urandom),
                      $urandom_range(9) == 0);
        end
    endtask

    // Waits until every queued result has arrived, then lets the pipeline settle so
    // that items which cause no result have also left the block.
    task automatic wait_decoder_idle();
        rx_ch.valid <= 1'b0;
        while (decoded_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_payload_limit(input logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        limit_shadow = value;
    endtask

    // Mostly well-formed frames with random content; the rest are noise, truncated
    // frames and stray resyncs. A truncated frame is usually followed by a resync.
    task automatic run_random_traffic(input int count);
        int target;
        int pick;
        bit resync_next;
        target      = frame_items + count;
        resync_next = 1'b1;
        while (frame_items < target)
        begin
            pick = $urandom_range(99);
            if (pick < 72)
            begin
                send_random_frame(resync_next || ($urandom_range(3) == 0), -1);
                resync_next = 1'b0;
            end
            else if (pick < 84)
            begin
                send_noise();
            end
            else if (pick < 94)
            begin
                send_random_frame(resync_next, $urandom_range(12, 1));
                resync_next = ($urandom_range(3) != 0);
            end
            else
            begin
                send_byte(8'($urandom), 1'b1);
            end
        end
        wait_decoder_idle();
    endtask

    // Hand-made stream: repeated first magic, a zero-length frame with extreme header
    // fields, an oversized frame whose high length byte is the first magic, a frame
    // picked up straight from the second-magic state, and a resync in mid-frame.
    task automatic test_directed_frames();
        send_byte(crcdf_pkg::MAGIC_FIRST, 1'b0);
        frame_payload.delete();
        send_frame(16'h0000, 16'h0000, 8'hFF, 8'h00, 1'b0, 1'b0, 0, -1);
        send_frame(16'hFFFF, 16'hA500, 8'h00, 8'h00, 1'b0, 1'b0, 0, 6);
        frame_payload.delete();
        frame_payload.insert(frame_payload.size(), 8'h00);
        // Skip the first magic byte: the decoder is already waiting for the second.
        send_frame(16'h1234, 16'h0001, 8'h00, 8'hFF, 1'b0, 1'b0, 1, 9);
        // The CRC never comes; the resync abandons the frame without a report.
        send_byte(8'h77, 1'b1);
        wait_decoder_idle();
    endtask

    task automatic test_random_frames();
        run_random_traffic(500);
    endtask

    // With a zero limit only empty frames pass; with the largest limit nothing is
    // ever dropped for its length.
    task automatic test_limit_extremes();
        write_payload_limit(16'h0000);
        run_random_traffic(200);
        write_payload_limit(16'hFFFF);
        run_random_traffic(300);
    endtask

    // The receiver holds off for a long stretch while a long frame is offered, so
    // both registers of the block fill and the input channel has to stall.
    task automatic test_backpressure_fill();
        hold_request = HOLD_OFF_CYCLES;
        fill_payload(40);
        send_frame(16'($urandom), 16'd40, 8'($urandom), 8'($urandom), 1'b0, 1'b1, 0, -1);
        wait_decoder_idle();
    endtask

    // Small limits put the length check right next to the payloads that are sent.
    task automatic test_limit_midrange();
        write_payload_limit(16'($urandom_range(40, 1)));
        run_random_traffic(350);
        write_payload_limit(crcdf_pkg::LIMIT_RESET);
        run_random_traffic(200);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver: random ready, or held low while a requested hold-off runs out.
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Every accepted result is compared with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        crcdf_pkg::result_t got;
        crcdf_pkg::result_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            got = {res_ch.out_kind, res_ch.out_byte, res_ch.frame_nonce, res_ch.frame_type,
                   res_ch.frame_sequence, res_ch.frame_length, res_ch.crc_ok, res_ch.last};
            if (decoded_queue.size() == 0)
            begin
                $error("unexpected result item: out_kind %0d, out_byte 0x%0h",
                       got.out_kind, got.out_byte);
                mismatch_count++;
            end
            else
            begin
                want = decoded_queue.pop_front();
                check_field("out_kind", 16'(want.out_kind), 16'(got.out_kind));
                check_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
                check_field("frame_nonce", want.frame_nonce, got.frame_nonce);
                check_field("frame_type", 16'(want.frame_type), 16'(got.frame_type));
                check_field("frame_sequence", 16'(want.frame_sequence),
                            16'(got.frame_sequence));
                check_field("frame_length", want.frame_length, got.frame_length);
                check_field("crc_ok", 16'(want.crc_ok), 16'(got.crc_ok));
                check_field("last", 16'(want.last), 16'(got.last));
            end
        end
    end

    // Ends the run if neither channel moves an item for too long.
    always @(posedge clk)
    begin
        if ((rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        rx_ch.resync  <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= 16'h0000;
        src_idle_pct   = 0;
        sink_idle_pct  = 0;
        hold_request   = 0;
        idle_cycles    = 0;
        mismatch_count = 0;
        frame_items    = 0;
        // Decoder model starts from the block's reset state.
        hunt_state   = crcdf_pkg::ST_MAGIC1;
        limit_shadow = crcdf_pkg::LIMIT_RESET;
        hdr_nonce    = '0;
        hdr_length   = '0;
        hdr_type     = '0;
        hdr_seq      = '0;
        payload_seen = '0;
        crc_acc      = crcdf_pkg::CRC_SEED;
        crc_low_rx   = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender mostly busy, receiver often stalling.
        src_idle_pct  = 7;
        sink_idle_pct = 58;
        test_directed_frames();
        test_random_frames();

        // Sender often idle, receiver mostly ready.
        src_idle_pct  = 58;
        sink_idle_pct = 7;
        test_limit_extremes();

        // Full rate on both sides.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_backpressure_fill();
        test_limit_midrange();

        wait_decoder_idle();
        // A stray result after the last expected one would show up here.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== crc16_frame_deframer_core.f =====
src/crcdf_pkg.sv
src/crcdf_if.sv
src/crcdf_parser.sv
src/crc16_frame_deframer_core.sv
tb/sv/tb_crc16_frame_deframer_core.sv
